>>> sv/itp_pkg.sv
// shared types, token codes and helpers for the infix to postfix converter
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int OKIND_W = 2;
    localparam int ENTRY_W = 3;

    localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd4;

    localparam logic [OKIND_W-1:0] OUT_NUMBER   = 2'd0;
    localparam logic [OKIND_W-1:0] OUT_OPERATOR = 2'd1;
    localparam logic [OKIND_W-1:0] OUT_END      = 2'd2;

    typedef logic [ENTRY_W-1:0] t_entry;

    localparam t_entry ENTRY_LPAREN = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [OP_W-1:0]    op_code;
        logic [VALUE_W-1:0] number_value;
    } t_in_beat;

    typedef struct packed {
        logic [OKIND_W-1:0] out_kind;
        logic [OP_W-1:0]    out_op;
        logic [VALUE_W-1:0] out_value;
        logic               overflow_seen;
        logic               last_of_run;
    } t_out_beat;

    // high precedence group is times and divide
    function automatic logic prec_ge(input t_entry top, input logic [OP_W-1:0] code);
        prec_ge = (top[1] >= code[1]);
    endfunction

    function automatic t_out_beat make_beat(input logic [OKIND_W-1:0] kind,
                                            input logic [OP_W-1:0] op,
                                            input logic [VALUE_W-1:0] value,
                                            input logic ovf,
                                            input logic last);
        t_out_beat b;
        b.out_kind      = kind;
        b.out_op        = op;
        b.out_value     = value;
        b.overflow_seen = ovf;
        b.last_of_run   = last;
        make_beat = b;
    endfunction

endpackage

>>> sv/infix_to_postfix_converter_unit.sv
// shunting-yard infix to postfix converter with the operator stack held in ram
// numbers, left parens and operators that pop nothing are taken at one beat per cycle
// unless the output stalls; each popped entry passes S_POP (ram read), then S_CHK
// (read data used); a right paren that discards a left paren reloads the top in S_FILL
// the end marker leaves from S_ENDM after the last pop; results leave through one register
// synchronous active-low reset clears the count, the overflow flag and the output valid
module infix_to_postfix_converter_unit import itp_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TWO  = CW'(2);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_POP  = 6'b000010,
        S_CHK  = 6'b000100,
        S_ENDM = 6'b001000,
        S_FILL = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;
    t_entry            r_top, n_top;
    t_entry            r_pop, n_pop;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [OP_W-1:0]   r_code, n_code;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;
    logic [CW-1:0] cnt_m2;
    logic          out_free, in_accept, cont;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && (r_state == S_IDLE) && out_free;
    assign cnt_m2    = r_count - TWO;
    assign ram_raddr = cnt_m2[AW-1:0];
    assign ram_waddr = r_count[AW-1:0];
    assign cont      = (r_count != '0) && (ram_rdata != ENTRY_LPAREN)
                       && prec_ge(ram_rdata, r_code);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_top       = r_top;
        n_pop       = r_pop;
        n_kind      = r_kind;
        n_code      = r_code;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = ENTRY_LPAREN;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_kind = i_in_data.token_kind;
                    n_code = i_in_data.op_code;
                    unique case (i_in_data.token_kind)
                        KIND_NUMBER: begin
                            n_out_valid = 1'b1;
                            n_out = make_beat(OUT_NUMBER, '0, i_in_data.number_value,
                                              1'b0, 1'b1);
                        end
                        KIND_LPAREN: begin
                            if (r_count == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = ENTRY_LPAREN;
                                n_top     = ENTRY_LPAREN;
                                n_count   = r_count + ONE;
                            end
                        end
                        KIND_RPAREN: begin
                            if (r_count != '0) begin
                                if (r_top == ENTRY_LPAREN) begin
                                    n_count = r_count - ONE;
                                    if (r_count >= TWO) begin
                                        ram_re  = 1'b1;
                                        n_state = S_FILL;
                                    end
                                end else begin
                                    n_state = S_POP;
                                end
                            end
                        end
                        KIND_OPERATOR: begin
                            if (r_count != '0 && r_top != ENTRY_LPAREN
                                && prec_ge(r_top, i_in_data.op_code)) begin
                                n_state = S_POP;
                            end else if (r_count == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = {1'b0, i_in_data.op_code};
                                n_top     = {1'b0, i_in_data.op_code};
                                n_count   = r_count + ONE;
                            end
                        end
                        KIND_END: begin
                            if (r_count != '0) begin
                                n_state = S_POP;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out = make_beat(OUT_END, '0, '0, r_ovf, 1'b1);
                                n_ovf = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                n_pop   = r_top;
                n_count = r_count - ONE;
                ram_re  = (r_count >= TWO);
                n_state = S_CHK;
            end
            S_CHK: begin
                case (r_kind)
                    KIND_RPAREN: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_top       = ram_rdata;
                            if (r_count == '0) begin
                                n_out   = make_beat(OUT_OPERATOR, r_pop[OP_W-1:0], '0,
                                                    1'b0, 1'b1);
                                n_state = S_IDLE;
                            end else if (ram_rdata == ENTRY_LPAREN) begin
                                n_out   = make_beat(OUT_OPERATOR, r_pop[OP_W-1:0], '0,
                                                    1'b0, 1'b1);
                                n_count = r_count - ONE;
                                if (r_count >= TWO) begin
                                    ram_re  = 1'b1;
                                    n_state = S_FILL;
                                end else begin
                                    n_state = S_IDLE;
                                end
                            end else begin
                                n_out   = make_beat(OUT_OPERATOR, r_pop[OP_W-1:0], '0,
                                                    1'b0, 1'b0);
                                n_state = S_POP;
                            end
                        end
                    end
                    KIND_OPERATOR: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out = make_beat(OUT_OPERATOR, r_pop[OP_W-1:0], '0,
                                              1'b0, !cont);
                            if (cont) begin
                                n_top   = ram_rdata;
                                n_state = S_POP;
                            end else begin
                                // the pop left room, so this push always lands
                                ram_we    = 1'b1;
                                ram_wdata = {1'b0, r_code};
                                n_top     = {1'b0, r_code};
                                n_count   = r_count + ONE;
                                n_state   = S_IDLE;
                            end
                        end
                    end
                    KIND_END: begin
                        if (r_pop == ENTRY_LPAREN || out_free) begin
                            if (r_pop != ENTRY_LPAREN) begin
                                n_out_valid = 1'b1;
                                n_out = make_beat(OUT_OPERATOR, r_pop[OP_W-1:0], '0,
                                                  1'b0, 1'b0);
                            end
                            n_top   = ram_rdata;
                            n_state = (r_count != '0) ? S_POP : S_ENDM;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ENDM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out   = make_beat(OUT_END, '0, '0, r_ovf, 1'b1);
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                n_top   = ram_rdata;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_top  <= n_top;
        r_pop  <= n_pop;
        r_kind <= n_kind;
        r_code <= n_code;
    end

    itp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("stack count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP || r_state == S_FILL) |-> r_count != '0)
        else $error("pop or reload on empty stack");

    a_ovf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && out_free && n_out.out_kind == OUT_END) |=> !r_ovf)
        else $error("overflow flag survived end marker");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_kind != OUT_OPERATOR) |->
            o_out_data.last_of_run)
        else $error("number or end marker without last flag");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_count < FULL)
        else $error("stack write while full");

endmodule

>>> sv/itp_ram.sv
// generic single-port-write, single-port-read ram with registered read
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
